// ===== sv/pc_pkg.sv =====
// shared constants, types and sequencer states of the polygon clipper
`default_nettype none
package pc_pkg;

  localparam int MAX_CLIP_VERTS = 8;
  localparam int MAX_POLY_VERTS = 32;

  localparam int CIW = $clog2(MAX_CLIP_VERTS);
  localparam int CCW = $clog2(MAX_CLIP_VERTS + 1);
  localparam int PIW = $clog2(MAX_POLY_VERTS);
  localparam int PCW = $clog2(MAX_POLY_VERTS + 1);

  // datapath widths
  localparam int DW  = 33;       // coordinate difference
  localparam int PRW = 2 * DW;   // product
  localparam int NW  = PRW + 1;  // numerator and denominator
  localparam int PW  = NW + 32;  // scaled numerator
  localparam int QCW = $clog2(PW);
  localparam int QSH = 40;       // quotient clamp exponent
  localparam int QMW = QSH + 1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } vtx_t;

  localparam logic OP_CLIP = 1'b0;
  localparam logic OP_SUBJ = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE, S_EDGE, S_C0, S_C1, S_SRD,
    S_INA, S_INB, S_INC, S_IND, S_LDE, S_DEC,
    S_X0, S_X1, S_X2, S_X3, S_X4, S_X5, S_ZCHK,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_DIV, S_RND1, S_RND2,
    S_PUSHX, S_PUSHE, S_NEXT, S_EEND,
    S_ORD, S_OLD, S_OHOLD
  } pc_state_t;

endpackage
`default_nettype wire

// ===== sv/polygon_clipper.sv =====
// Sutherland-Hodgman polygon clipper, top level
// Clip vertices and subject vertices are taken one item per cycle; the clip polygon
// stays loaded across subjects. The subject's last vertex starts the clipping pass,
// during which no item is taken. Each clip edge carries an overhead for edge fetch,
// first inside test and bank swap. Each subject vertex then costs an inside test and
// bookkeeping, plus a write for each vertex pushed. Each crossing point adds the work
// of the single shared 33x33 multiplier and the bit-serial divider, which produces one
// quotient bit a cycle. The working polygon sits in one ping-pong memory with one read
// port. Emitting the result therefore steps through a read, a load and a hold state
// per vertex, and waits in the hold state while the output is stalled.
`default_nettype none
module polygon_clipper import pc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire logic signed [31:0] in_vert_x,
  input  wire logic signed [31:0] in_vert_y,
  input  wire logic               in_is_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_x,
  output logic signed [31:0]      out_y,
  output logic                    out_last,
  output logic                    out_empty_result,
  output logic                    out_overflow
);

  pc_state_t state_r, state_nxt;

  // memories
  vtx_t clip_mem [MAX_CLIP_VERTS];
  vtx_t work_mem [2 * MAX_POLY_VERTS];
  vtx_t clip_rd_r, work_rd_r;
  logic           clip_we;
  logic [CIW-1:0] clip_waddr, clip_raddr;
  logic           work_we;
  logic [PIW:0]   work_waddr, work_raddr;
  vtx_t           work_wdata;

  // control
  logic [CCW-1:0] clip_count_r, i_r;
  logic           clip_closed_r, ovf_r, bank_r;
  logic [PCW-1:0] vcount_r, n_r, m_r, j_r, k_r;
  logic           is_first_r, ins_r, ine_r, coord_r;

  // datapath
  vtx_t c0_r, c1_r, s_r, e_r;
  logic signed [31:0]  cx_r, cy_r;
  logic signed [DW-1:0]  ma_r, mb_r;
  logic signed [PRW-1:0] prod_r, acc_r;
  logic signed [NW-1:0]  den_r, num_r;
  logic [NW-1:0]  numm_r, denm_r, r_r;
  logic [PW-1:0]  p_r, q_r;
  logic [QCW-1:0] dcnt_r;
  logic [QMW-1:0] qm_r;
  logic           neg_r;

  logic signed [31:0] out_x_r, out_y_r;
  logic out_valid_r, out_last_r, out_empty_r, out_ovf_r;

  function automatic logic signed [DW-1:0] sdiff(logic signed [31:0] a, logic signed [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  function automatic logic [PCW-1:0] wrap_inc(logic [PCW-1:0] v, logic [PCW-1:0] n);
    return (v + PCW'(1) == n) ? '0 : v + PCW'(1);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [42:0] v);
    logic signed [31:0] res;
    if (v[42:31] == '0 || v[42:31] == '1) res = v[31:0];
    else if (v[42]) res = 32'sh8000_0000;
    else res = 32'sh7fff_ffff;
    return res;
  endfunction

  localparam logic [PW:0] QLIM = {{(PW-QSH){1'b0}}, 1'b1, {QSH{1'b0}}};

  // combinational helpers
  vtx_t q_pt;
  logic signed [DW-1:0] d12x, d12y, d34x, d34y, dsel;
  logic [DW-2:0] dmag;
  logic in_res, clip_room, subj_room, acc_sub, out_acc;
  logic [CCW-1:0] i_nxt;
  logic [PCW-1:0] e_idx, e_idx_next;
  logic [NW:0]   rs, rsub, r2;
  logic          rge, rinc;
  logic [PW:0]   qi;
  logic signed [42:0] qv, sv, sum;
  logic signed [31:0] p1c;
  logic [PCW-1:0] vcount_inc;

  always_comb begin
    q_pt = is_first_r ? s_r : e_r;
    d12x = sdiff(e_r.x, s_r.x);
    d12y = sdiff(e_r.y, s_r.y);
    d34x = sdiff(c1_r.x, c0_r.x);
    d34y = sdiff(c1_r.y, c0_r.y);
    dsel = coord_r ? d12y : d12x;
    dmag = dsel[DW-1] ? (DW-1)'(-dsel) : dsel[DW-2:0];
    in_res = acc_r <= prod_r;
    clip_room = clip_closed_r || (clip_count_r < CCW'(MAX_CLIP_VERTS));
    subj_room = vcount_r < PCW'(MAX_POLY_VERTS);
    vcount_inc = subj_room ? vcount_r + PCW'(1) : vcount_r;
    acc_sub = in_valid && !in_stall;
    out_acc = out_valid_r && !out_stall;
    i_nxt = (i_r + CCW'(1) == clip_count_r) ? '0 : i_r + CCW'(1);
    e_idx = wrap_inc(j_r, n_r);
    e_idx_next = wrap_inc(j_r + PCW'(1), n_r);
    rs = {r_r, p_r[PW-1]};
    rge = rs >= {1'b0, denm_r};
    rsub = rs - {1'b0, denm_r};
    r2 = {r_r, 1'b0};
    rinc = r2 >= {1'b0, denm_r};
    qi = {1'b0, q_r} + (PW+1)'(rinc);
    p1c = coord_r ? s_r.y : s_r.x;
    qv = {2'b00, qm_r};
    sv = neg_r ? -qv : qv;
    sum = {{11{p1c[31]}}, p1c} + sv;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (acc_sub && in_operation == OP_SUBJ && in_is_last) state_nxt = S_EDGE;
      S_EDGE: begin
        if (i_r == clip_count_r) state_nxt = (n_r == '0) ? S_OHOLD : S_ORD;
        else state_nxt = S_C0;
      end
      S_C0:    state_nxt = S_C1;
      S_C1:    state_nxt = (n_r == '0) ? S_EEND : S_SRD;
      S_SRD:   state_nxt = S_INA;
      S_INA:   state_nxt = S_INB;
      S_INB:   state_nxt = S_INC;
      S_INC:   state_nxt = S_IND;
      S_IND:   state_nxt = is_first_r ? S_LDE : S_DEC;
      S_LDE:   state_nxt = S_INA;
      S_DEC: begin
        if (ine_r != ins_r) state_nxt = S_X0;
        else if (ine_r) state_nxt = S_PUSHE;
        else state_nxt = S_NEXT;
      end
      S_X0:    state_nxt = S_X1;
      S_X1:    state_nxt = S_X2;
      S_X2:    state_nxt = S_X3;
      S_X3:    state_nxt = S_X4;
      S_X4:    state_nxt = S_X5;
      S_X5:    state_nxt = S_ZCHK;
      S_ZCHK:  state_nxt = (den_r == '0) ? S_PUSHX : S_M0;
      S_M0:    state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_DIV;
      S_DIV:   if (dcnt_r == QCW'(PW - 1)) state_nxt = S_RND1;
      S_RND1:  state_nxt = S_RND2;
      S_RND2:  state_nxt = coord_r ? S_PUSHX : S_M0;
      S_PUSHX: state_nxt = ine_r ? S_PUSHE : S_NEXT;
      S_PUSHE: state_nxt = S_NEXT;
      S_NEXT:  state_nxt = (j_r + PCW'(1) == n_r) ? S_EEND : S_LDE;
      S_EEND:  state_nxt = S_EDGE;
      S_ORD:   state_nxt = S_OLD;
      S_OLD:   state_nxt = S_OHOLD;
      S_OHOLD: if (out_acc) state_nxt = out_last_r ? S_IDLE : S_ORD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake and memory controls
  always_comb begin
    in_stall   = state_r != S_IDLE;
    clip_we    = 1'b0;
    clip_waddr = clip_closed_r ? '0 : clip_count_r[CIW-1:0];
    clip_raddr = '0;
    work_we    = 1'b0;
    work_waddr = {bank_r, vcount_r[PIW-1:0]};
    work_wdata = '{x: in_vert_x, y: in_vert_y};
    work_raddr = '0;
    case (state_r)
      S_IDLE: begin
        if (acc_sub && in_operation == OP_CLIP) clip_we = clip_room;
        if (acc_sub && in_operation == OP_SUBJ) work_we = subj_room;
      end
      S_EDGE:  clip_raddr = i_r[CIW-1:0];
      S_C0:    clip_raddr = i_nxt[CIW-1:0];
      S_C1:    work_raddr = {bank_r, {PIW{1'b0}}};
      S_IND: begin
        work_raddr = {bank_r, e_idx[PIW-1:0]};
      end
      S_NEXT: begin
        work_raddr = {bank_r, e_idx_next[PIW-1:0]};
      end
      S_PUSHX: begin
        work_we    = m_r < PCW'(MAX_POLY_VERTS);
        work_waddr = {~bank_r, m_r[PIW-1:0]};
        work_wdata = '{x: cx_r, y: cy_r};
      end
      S_PUSHE: begin
        work_we    = m_r < PCW'(MAX_POLY_VERTS);
        work_waddr = {~bank_r, m_r[PIW-1:0]};
        work_wdata = e_r;
      end
      S_ORD:   work_raddr = {bank_r, k_r[PIW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clip_we) clip_mem[clip_waddr] <= '{x: in_vert_x, y: in_vert_y};
    clip_rd_r <= clip_mem[clip_raddr];
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_waddr] <= work_wdata;
    work_rd_r <= work_mem[work_raddr];
  end

  always_ff @(posedge clk) begin
    prod_r <= ma_r * mb_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      clip_count_r  <= '0;
      clip_closed_r <= 1'b0;
      vcount_r      <= '0;
      ovf_r         <= 1'b0;
      bank_r        <= 1'b0;
      n_r           <= '0;
      m_r           <= '0;
      j_r           <= '0;
      k_r           <= '0;
      i_r           <= '0;
      is_first_r    <= 1'b0;
      coord_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (acc_sub && in_operation == OP_CLIP) begin
            if (clip_room) clip_count_r <= clip_closed_r ? CCW'(1) : clip_count_r + CCW'(1);
            else ovf_r <= 1'b1;
            clip_closed_r <= in_is_last;
          end
          if (acc_sub && in_operation == OP_SUBJ) begin
            vcount_r <= vcount_inc;
            if (!subj_room) ovf_r <= 1'b1;
            if (in_is_last) begin
              n_r <= vcount_inc;
              i_r <= '0;
            end
          end
        end
        S_EDGE: begin
          k_r <= '0;
          if (i_r == clip_count_r && n_r == '0) begin
            out_x_r     <= '0;
            out_y_r     <= '0;
            out_last_r  <= 1'b1;
            out_empty_r <= 1'b1;
            out_ovf_r   <= ovf_r;
            out_valid_r <= 1'b1;
          end
        end
        S_C0: c0_r <= clip_rd_r;
        S_C1: begin
          c1_r       <= clip_rd_r;
          m_r        <= '0;
          j_r        <= '0;
          is_first_r <= 1'b1;
        end
        S_SRD: s_r <= work_rd_r;
        S_INA: begin
          ma_r <= sdiff(c1_r.x, c0_r.x);
          mb_r <= sdiff(q_pt.y, c0_r.y);
        end
        S_INB: begin
          ma_r <= sdiff(c1_r.y, c0_r.y);
          mb_r <= sdiff(q_pt.x, c0_r.x);
        end
        S_INC: acc_r <= prod_r;
        S_IND: begin
          if (is_first_r) begin
            ins_r      <= in_res;
            is_first_r <= 1'b0;
          end else begin
            ine_r <= in_res;
          end
        end
        S_LDE: e_r <= work_rd_r;
        S_X0: begin
          ma_r    <= d12x;
          mb_r    <= d34y;
          coord_r <= 1'b0;
        end
        S_X1: begin
          ma_r <= d12y;
          mb_r <= d34x;
        end
        S_X2: begin
          acc_r <= prod_r;
          ma_r  <= sdiff(c0_r.x, s_r.x);
          mb_r  <= d34y;
        end
        S_X3: begin
          den_r <= {acc_r[PRW-1], acc_r} - {prod_r[PRW-1], prod_r};
          ma_r  <= sdiff(c0_r.y, s_r.y);
          mb_r  <= d34x;
        end
        S_X4: acc_r <= prod_r;
        S_X5: num_r <= {acc_r[PRW-1], acc_r} - {prod_r[PRW-1], prod_r};
        S_ZCHK: begin
          numm_r <= num_r[NW-1] ? -num_r : num_r;
          denm_r <= den_r[NW-1] ? -den_r : den_r;
          if (den_r == '0) begin
            cx_r <= s_r.x;
            cy_r <= s_r.y;
          end
        end
        // scaled numerator from two 32-bit slices and a top slice
        S_M0: begin
          ma_r <= {1'b0, numm_r[31:0]};
          mb_r <= {1'b0, dmag};
        end
        S_M1: ma_r <= {1'b0, numm_r[63:32]};
        S_M2: begin
          p_r  <= {{(PW-64){1'b0}}, prod_r[63:0]};
          ma_r <= {1'b0, {(DW-1-(NW-64)){1'b0}}, numm_r[NW-1:64]};
        end
        S_M3: p_r <= p_r + {{(PW-96){1'b0}}, prod_r[63:0], 32'b0};
        S_M4: begin
          p_r    <= p_r + {prod_r[PW-65:0], 64'b0};
          r_r    <= '0;
          q_r    <= '0;
          dcnt_r <= '0;
        end
        S_DIV: begin
          r_r    <= rge ? rsub[NW-1:0] : rs[NW-1:0];
          q_r    <= {q_r[PW-2:0], rge};
          p_r    <= {p_r[PW-2:0], 1'b0};
          dcnt_r <= dcnt_r + QCW'(1);
        end
        S_RND1: begin
          qm_r  <= (qi > QLIM) ? QLIM[QMW-1:0] : qi[QMW-1:0];
          neg_r <= num_r[NW-1] ^ den_r[NW-1] ^ dsel[DW-1];
        end
        S_RND2: begin
          if (coord_r) cy_r <= sat32(sum);
          else cx_r <= sat32(sum);
          coord_r <= 1'b1;
        end
        S_PUSHX, S_PUSHE: begin
          if (m_r < PCW'(MAX_POLY_VERTS)) m_r <= m_r + PCW'(1);
          else ovf_r <= 1'b1;
        end
        S_NEXT: begin
          ins_r <= ine_r;
          s_r   <= e_r;
          j_r   <= j_r + PCW'(1);
        end
        S_EEND: begin
          n_r    <= m_r;
          bank_r <= ~bank_r;
          i_r    <= i_r + CCW'(1);
        end
        S_OLD: begin
          out_x_r     <= work_rd_r.x;
          out_y_r     <= work_rd_r.y;
          out_last_r  <= k_r + PCW'(1) == n_r;
          out_empty_r <= 1'b0;
          out_ovf_r   <= ovf_r;
          out_valid_r <= 1'b1;
        end
        S_OHOLD: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            k_r         <= k_r + PCW'(1);
            if (out_last_r) begin
              vcount_r <= '0;
              ovf_r    <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_last         = out_last_r;
  assign out_empty_result = out_empty_r;
  assign out_overflow     = out_ovf_r;

  // output fill index never passes the buffer size
  a_push_bound: assert property (@(posedge clk) disable iff (!rst_n)
    m_r <= PCW'(MAX_POLY_VERTS))
    else $error("push count beyond buffer");

  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    clip_count_r <= CCW'(MAX_CLIP_VERTS))
    else $error("clip count beyond store");

  // divider remainder stays below the divisor
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RND1 |-> r_r < denm_r)
    else $error("divider remainder not reduced");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && n_r == '0)
    else $error("empty item not final");

endmodule
`default_nettype wire

// ===== verif/tb_polygon_clipper.sv =====
// self-checking testbench for the polygon clipper: directed and random polygons against a predictor
`timescale 1ns / 100ps
module tb_polygon_clipper;
  import pc_pkg::*;

  localparam int CYCLE_LIMIT = 30000000;
  localparam int RANDOM_ITEMS = 370;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               last;
    logic               empty;
    logic               ovf;
  } clipped_vert_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = OP_CLIP;
  logic signed [31:0] in_vert_x = '0;
  logic signed [31:0] in_vert_y = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic out_last;
  logic out_empty_result;
  logic out_overflow;

  polygon_clipper i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_vert_x(in_vert_x), .in_vert_y(in_vert_y), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_x(out_x), .out_y(out_y),
    .out_last(out_last), .out_empty_result(out_empty_result), .out_overflow(out_overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  vtx_t clip_pts[MAX_CLIP_VERTS];
  int   clip_n = 0;
  bit   clip_done = 1'b0;
  vtx_t subj_pts[MAX_POLY_VERTS];
  int   subj_n = 0;
  bit   ovf_flag = 1'b0;

  clipped_vert_t pending_verts[$];
  int  mismatches = 0;
  int  items_sent = 0;
  int  cycles = 0;
  bit  calm = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  stall_run = 0;

  function automatic bit on_keep_side(vtx_t c0, vtx_t c1, vtx_t q);
    logic signed [127:0] ex, ey, qx, qy;
    ex = c1.x; ex = ex - c0.x;
    ey = c1.y; ey = ey - c0.y;
    qx = q.x;  qx = qx - c0.x;
    qy = q.y;  qy = qy - c0.y;
    return (ex * qy - ey * qx) <= 0;
  endfunction

  // num * d / den, rounded to nearest with ties away from zero, magnitude clamped at 2^40
  function automatic logic signed [63:0] scaled_quot(logic signed [127:0] num,
                                                    logic signed [127:0] d,
                                                    logic signed [127:0] den);
    logic signed [191:0] p, pd, dd;
    logic [191:0] mp, md, q;
    pd = d; p = num; p = p * pd; dd = den;
    mp = p < 0 ? -p : p;
    md = dd < 0 ? -dd : dd;
    q = (2 * mp + md) / (2 * md);
    if (q > (192'd1 << 40)) q = 192'd1 << 40;
    return ((p < 0) != (dd < 0)) ? -$signed(64'(q)) : $signed(64'(q));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7fffffff) return S32_MAX;
    if (v < -64'sh80000000) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic vtx_t crossing(vtx_t p1, vtx_t p2, vtx_t p3, vtx_t p4);
    logic signed [127:0] ax, ay, bx, by, ox, oy, den, num;
    logic signed [63:0] sx, sy;
    vtx_t r;
    ax = p2.x; ax = ax - p1.x;  ay = p2.y; ay = ay - p1.y;
    bx = p4.x; bx = bx - p3.x;  by = p4.y; by = by - p3.y;
    ox = p3.x; ox = ox - p1.x;  oy = p3.y; oy = oy - p1.y;
    den = ax * by - ay * bx;
    if (den == 0) return p1;
    num = ox * by - oy * bx;
    sx = p1.x; sx = sx + scaled_quot(num, ax, den);
    sy = p1.y; sy = sy + scaled_quot(num, ay, den);
    r.x = sat32(sx);
    r.y = sat32(sy);
    return r;
  endfunction

  function automatic void push_vert(ref vtx_t b[MAX_POLY_VERTS], ref int m, input vtx_t v);
    if (m < MAX_POLY_VERTS) begin
      b[m] = v;
      m++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  // track one accepted item and queue the clipped polygon it completes
  function automatic void clip_subject(logic op, vtx_t v, logic last);
    vtx_t a[MAX_POLY_VERTS];
    vtx_t b[MAX_POLY_VERTS];
    int n, m;
    vtx_t c0, c1, s, e;
    bit ins, ine;
    clipped_vert_t r;
    if (op == OP_CLIP) begin
      if (clip_done) begin
        clip_n = 0;
        clip_done = 1'b0;
      end
      if (clip_n < MAX_CLIP_VERTS) begin
        clip_pts[clip_n] = v;
        clip_n++;
      end else begin
        ovf_flag = 1'b1;
      end
      if (last) clip_done = 1'b1;
      return;
    end
    if (subj_n < MAX_POLY_VERTS) begin
      subj_pts[subj_n] = v;
      subj_n++;
    end else begin
      ovf_flag = 1'b1;
    end
    if (!last) return;
    a = subj_pts;
    n = subj_n;
    for (int i = 0; i < clip_n; i++) begin
      c0 = clip_pts[i];
      c1 = clip_pts[(i + 1) % clip_n];
      m = 0;
      for (int j = 0; j < n; j++) begin
        s = a[j];
        e = a[(j + 1) % n];
        ine = on_keep_side(c0, c1, e);
        ins = on_keep_side(c0, c1, s);
        if (ine) begin
          if (!ins) push_vert(b, m, crossing(s, e, c0, c1));
          push_vert(b, m, e);
        end else if (ins) begin
          push_vert(b, m, crossing(s, e, c0, c1));
        end
      end
      a = b;
      n = m;
    end
    if (n == 0) begin
      r = '{x: 0, y: 0, last: 1'b1, empty: 1'b1, ovf: ovf_flag};
      pending_verts = {pending_verts, r};
    end else begin
      for (int k = 0; k < n; k++) begin
        r = '{x: a[k].x, y: a[k].y, last: (k == n - 1), empty: 1'b0, ovf: ovf_flag};
        pending_verts = {pending_verts, r};
      end
    end
    subj_n = 0;
    ovf_flag = 1'b0;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_vertex(logic op, logic signed [31:0] x, logic signed [31:0] y,
                             logic last);
    int gap;
    vtx_t v;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_vert_x <= x;
    in_vert_y <= y;
    in_is_last <= last;
    do @(posedge clk); while (in_stall);
    v.x = x;
    v.y = y;
    clip_subject(op, v, last);
    items_sent++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_verts.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic send_square(int lo, int hi);
    send_vertex(OP_CLIP, lo, lo, 1'b0);
    send_vertex(OP_CLIP, lo, hi, 1'b0);
    send_vertex(OP_CLIP, hi, hi, 1'b0);
    send_vertex(OP_CLIP, hi, lo, 1'b1);
  endtask

  function automatic logic signed [31:0] rand_coord(int scale);
    if (scale >= 31) return $urandom;
    return $signed($urandom_range((1 << scale) * 2)) - (1 << scale);
  endfunction

  task automatic send_polygon(logic op, int count, int scale, bit close_it);
    for (int i = 0; i < count; i++)
      send_vertex(op, rand_coord(scale), rand_coord(scale), close_it && (i == count - 1));
  endtask

  task automatic test_no_clip();
    send_vertex(OP_SUBJ, 32'sd65536, 32'sd131072, 1'b0);
    send_vertex(OP_SUBJ, -32'sd3, 32'sd4, 1'b0);
    send_vertex(OP_SUBJ, 32'sd5, -32'sd6, 1'b1);
  endtask

  task automatic test_empty_result();
    send_square(0, 10 << 16);
    send_vertex(OP_SUBJ, -(20 << 16), 0, 1'b0);
    send_vertex(OP_SUBJ, -(30 << 16), 5 << 16, 1'b0);
    send_vertex(OP_SUBJ, -(20 << 16), 9 << 16, 1'b1);
  endtask

  task automatic test_extremes();
    send_square(-(1 << 20), 1 << 20);
    send_vertex(OP_SUBJ, S32_MIN, S32_MIN, 1'b0);
    send_vertex(OP_SUBJ, S32_MIN, S32_MAX, 1'b0);
    send_vertex(OP_SUBJ, S32_MAX, 32'sd0, 1'b1);
    // clip polygon spanning the whole range
    send_vertex(OP_CLIP, S32_MIN, S32_MIN, 1'b0);
    send_vertex(OP_CLIP, S32_MIN, S32_MAX, 1'b0);
    send_vertex(OP_CLIP, S32_MAX, S32_MIN, 1'b1);
    send_vertex(OP_SUBJ, S32_MAX, S32_MAX, 1'b0);
    send_vertex(OP_SUBJ, 32'sd0, S32_MIN, 1'b0);
    send_vertex(OP_SUBJ, S32_MIN, 32'sd1, 1'b1);
  endtask

  task automatic test_open_clip();
    // clip polygon without its last flag, then grown after the subject
    send_vertex(OP_CLIP, 0, 0, 1'b0);
    send_vertex(OP_CLIP, 0, 8 << 16, 1'b0);
    send_vertex(OP_CLIP, 8 << 16, 8 << 16, 1'b0);
    send_polygon(OP_SUBJ, 4, 20, 1'b1);
    send_vertex(OP_CLIP, 8 << 16, 0, 1'b1);
    send_polygon(OP_SUBJ, 4, 20, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_drain();
    calm = 1'b1;
    hold_req = 2500;
    for (int i = 0; i < 4; i++) send_polygon(OP_SUBJ, 4, 16, 1'b1);
    calm = 1'b0;
    wait_drain();
  endtask

  task automatic test_random();
    int scale, r, count;
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      scale = ($urandom_range(9) == 0) ? 31 : $urandom_range(24, 6);
      calm = ($urandom_range(9) == 0);
      if (r < 40) begin
        count = ($urandom_range(9) == 0) ? $urandom_range(10, 9) : $urandom_range(8, 3);
        send_polygon(OP_CLIP, count, scale, $urandom_range(19) != 0);
      end
      for (int s = $urandom_range(3, 1); s > 0; s--) begin
        r = $urandom_range(99);
        if (r < 6) count = $urandom_range(35, 33);
        else if (r < 12) count = $urandom_range(2, 1);
        else count = $urandom_range(8, 3);
        send_polygon(OP_SUBJ, count, scale, 1'b1);
      end
      if ($urandom_range(14) == 0) test_backpressure();
    end
    calm = 1'b0;
  endtask

  // receiver stalls, including the long hold-off
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < 25) begin
      stall_run = ($urandom_range(19) == 0) ? $urandom_range(40, 10) : $urandom_range(2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    clipped_vert_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_verts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected vertex x=%0d y=%0d last=%0b empty=%0b ovf=%0b",
                   out_x, out_y, out_last, out_empty_result, out_overflow);
      end else begin
        want = pending_verts.pop_front();
        if (out_x !== want.x || out_y !== want.y || out_last !== want.last ||
            out_empty_result !== want.empty || out_overflow !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: exp x=%0d y=%0d l=%0b e=%0b o=%0b, got x=%0d y=%0d l=%0b e=%0b o=%0b",
                     want.x, want.y, want.last, want.empty, want.ovf,
                     out_x, out_y, out_last, out_empty_result, out_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polygon_clipper regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_no_clip();
    test_empty_result();
    test_extremes();
    test_open_clip();
    test_backpressure();
    test_random();
    wait_drain();
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_verts.size() == 0) begin
      $display("polygon_clipper regression: pass");
    end else begin
      $display("polygon_clipper regression: fail");
    end
    $finish;
  end

endmodule

// ===== polygon_clipper.f =====
sv/pc_pkg.sv
sv/polygon_clipper.sv
verif/tb_polygon_clipper.sv
